[hdl/assert_macros.svh]
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/voq_rr_pkg.sv]
// Package with field widths, codes and control types for the output queue block.
package voq_rr_pkg;

  localparam int KIND_W = 3;
  localparam int IDX_W  = 5;
  localparam int HND_W  = 16;
  localparam int ST_W   = 2;
  localparam int QLEN_W = 5;
  localparam int TOT_W  = 10;
  localparam int CFG_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ   = 3'd0,
    KIND_PEEK  = 3'd1,
    KIND_DEQ   = 3'd2,
    KIND_RR    = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REC_RD,
    S_UPDATE,
    S_HND_RD,
    S_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic take;
    logic select;
    logic clear_all;
    logic rec_read;
    logic update;
    logic capture;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_qop;
    logic is_clear;
    logic is_enq;
    logic is_rr;
    logic bad;
    logic rr_found;
    logic q_empty;
    logic out_free;
  } ctl_status_t;

endpackage

[hdl/voq_req_if.sv]
// Request channel: valid, ready and the request fields.
interface voq_req_if;
  import voq_rr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  output_index;
  logic [HND_W-1:0]  packet_handle;

  modport source (output valid, output kind, output output_index, output packet_handle,
                  input ready);
  modport sink (input valid, input kind, input output_index, input packet_handle,
                output ready);
endinterface

[hdl/voq_rsp_if.sv]
// Response channel: valid, ready and the response fields.
interface voq_rsp_if;
  import voq_rr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [HND_W-1:0]  handle_out;
  logic [IDX_W-1:0]  served_output;
  logic [QLEN_W-1:0] queue_length;
  logic [TOT_W-1:0]  total_packets;

  modport source (output valid, output status, output handle_out, output served_output,
                  output queue_length, output total_packets, input ready);
  modport sink (input valid, input status, input handle_out, input served_output,
                input queue_length, input total_packets, output ready);
endinterface

[hdl/voq_rr_ctl.sv]
// Controller state machine that steps one request through the queue datapath.
module voq_rr_ctl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  voq_rr_pkg::ctl_status_t  stat,
  output voq_rr_pkg::ctl_cmd_t     cmd
);
  import voq_rr_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.select    = 1'b1;
        cmd.clear_all = stat.is_clear;
        if (!stat.is_qop || stat.bad || (stat.is_rr && !stat.rr_found)) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_REC_RD;
        end
      end
      S_REC_RD: begin
        cmd.rec_read = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (!stat.is_enq && !stat.q_empty) begin
          state_next = S_HND_RD;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_HND_RD: begin
        cmd.capture = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/voq_rr_datapath.sv]
// Datapath: queue records, handle memory, round-robin search and response register.
module voq_rr_datapath #(
  parameter int MAX_OUTPUTS  = 32,
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [voq_rr_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic [voq_rr_pkg::KIND_W-1:0]         req_kind,
  input  logic [voq_rr_pkg::IDX_W-1:0]          req_output_index,
  input  logic [voq_rr_pkg::HND_W-1:0]          req_packet_handle,
  input  logic                                  rsp_ready,
  output logic                                  rsp_valid,
  output logic [voq_rr_pkg::ST_W-1:0]           rsp_status,
  output logic [voq_rr_pkg::HND_W-1:0]          rsp_handle_out,
  output logic [voq_rr_pkg::IDX_W-1:0]          rsp_served_output,
  output logic [voq_rr_pkg::QLEN_W-1:0]         rsp_queue_length,
  output logic [voq_rr_pkg::TOT_W-1:0]          rsp_total_packets,
  input  voq_rr_pkg::ctl_cmd_t                  cmd,
  output voq_rr_pkg::ctl_status_t               stat
);
  import voq_rr_pkg::*;

  localparam int QW        = $clog2(MAX_OUTPUTS);
  localparam int OW        = $clog2(MAX_OUTPUTS + 1);
  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES   = MAX_OUTPUTS * QUEUE_DEPTH;
  localparam int AW        = $clog2(ENTRIES);
  localparam int TW        = $clog2(ENTRIES + 1);
  localparam int CMPW      = ((OW > CFG_W) ? OW : CFG_W) + 1;
  localparam int OIU_RESET = (MAX_OUTPUTS < 32) ? MAX_OUTPUTS : 32;

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [CW-1:0] count;
  } rec_t;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  logic [OW-1:0]           oiu;
  logic [CMPW-1:0]         cfg_ext;
  logic [OW-1:0]           oiu_next;

  logic [KIND_W-1:0]       op_kind;
  logic [IDX_W-1:0]        op_idx;
  logic [HANDLE_WIDTH-1:0] op_hnd;

  logic                    is_enq;
  logic                    is_deq;
  logic                    is_rr;
  logic                    is_qop;
  logic                    bad;

  logic [MAX_OUTPUTS-1:0]  qvalid;
  logic [MAX_OUTPUTS-1:0]  nonempty;
  logic [TW-1:0]           total;

  logic                    hit_up;
  logic                    hit_any;
  logic [QW-1:0]           pos_up;
  logic [QW-1:0]           pos_any;
  logic                    rr_found;
  logic [QW-1:0]           rr_q;

  logic [QW-1:0]           sel_q;
  rec_t                    rec_mem [MAX_OUTPUTS];
  rec_t                    rec_rd;
  rec_t                    rec_eff;
  rec_t                    rec_new;
  logic                    rec_we;
  logic                    store_we;
  logic                    q_empty;
  logic                    q_full;
  logic [AW-1:0]           base_addr;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;

  logic [HANDLE_WIDTH-1:0] store [ENTRIES];
  logic [HANDLE_WIDTH-1:0] store_rd;

  status_code_t            res_status;
  logic [HND_W-1:0]        res_handle;
  logic [IDX_W-1:0]        res_served;
  logic [QLEN_W-1:0]       res_qlen;

  // Clamp the active output count to 1..MAX_OUTPUTS.
  always_comb begin
    cfg_ext = CMPW'(cfg_wr_data);
    if (cfg_ext == '0) begin
      oiu_next = OW'(1);
    end else if (cfg_ext > CMPW'(MAX_OUTPUTS)) begin
      oiu_next = OW'(MAX_OUTPUTS);
    end else begin
      oiu_next = OW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oiu <= OW'(OIU_RESET);
    end else if (cfg_wr_en) begin
      oiu <= oiu_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_kind <= req_kind;
      op_idx  <= req_output_index;
      op_hnd  <= HANDLE_WIDTH'(req_packet_handle);
    end
  end

  assign is_enq = (op_kind == KIND_ENQ);
  assign is_deq = (op_kind == KIND_DEQ);
  assign is_rr  = (op_kind == KIND_RR);
  assign is_qop = (op_kind <= KIND_RR);
  assign bad    = is_qop && (CMPW'(op_idx) >= CMPW'(oiu));

  // Rotating priority search over the active, non-empty queues.
  always_comb begin
    hit_up  = 1'b0;
    hit_any = 1'b0;
    pos_up  = '0;
    pos_any = '0;
    for (int i = MAX_OUTPUTS - 1; i >= 0; i--) begin
      if (nonempty[i] && (CMPW'(i) < CMPW'(oiu))) begin
        hit_any = 1'b1;
        pos_any = QW'(i);
        if (CMPW'(i) >= CMPW'(op_idx)) begin
          hit_up = 1'b1;
          pos_up = QW'(i);
        end
      end
    end
  end

  assign rr_found = hit_up || hit_any;
  assign rr_q     = hit_up ? pos_up : pos_any;

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      sel_q <= is_rr ? rr_q : QW'(op_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_read) begin
      rec_rd <= rec_mem[sel_q];
    end
    if (cmd.update && rec_we) begin
      rec_mem[sel_q] <= rec_new;
    end
  end

  assign rec_eff   = qvalid[sel_q] ? rec_rd : '0;
  assign q_empty   = (rec_eff.count == '0);
  assign q_full    = (rec_eff.count == CW'(QUEUE_DEPTH));
  assign base_addr = AW'(AW'(sel_q) * AW'(QUEUE_DEPTH));
  assign wr_addr   = AW'(base_addr + AW'(rec_eff.tail));
  assign rd_addr   = AW'(base_addr + AW'(rec_eff.head));

  always_comb begin
    rec_new  = rec_eff;
    rec_we   = 1'b0;
    store_we = 1'b0;
    if (is_enq) begin
      if (!q_full) begin
        rec_new.tail  = bump(rec_eff.tail);
        rec_new.count = CW'(rec_eff.count + 1'b1);
        rec_we        = 1'b1;
        store_we      = 1'b1;
      end
    end else if (!q_empty && (is_deq || is_rr)) begin
      rec_new.head  = bump(rec_eff.head);
      rec_new.count = CW'(rec_eff.count - 1'b1);
      rec_we        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && store_we) begin
      store[wr_addr] <= op_hnd;
    end
    if (cmd.update) begin
      store_rd <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid   <= '0;
      nonempty <= '0;
      total    <= '0;
    end else if (cmd.clear_all) begin
      qvalid   <= '0;
      nonempty <= '0;
      total    <= '0;
    end else if (cmd.update && rec_we) begin
      qvalid[sel_q]   <= 1'b1;
      nonempty[sel_q] <= (rec_new.count != '0);
      if (is_enq) begin
        total <= TW'(total + 1'b1);
      end else begin
        total <= TW'(total - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      if (bad) begin
        res_status <= ST_BAD;
      end else if (is_rr && !rr_found) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_OK;
      end
      res_handle <= '0;
      res_qlen   <= '0;
      if (!is_qop) begin
        res_served <= '0;
      end else if (is_rr && rr_found && !bad) begin
        res_served <= IDX_W'(rr_q);
      end else begin
        res_served <= op_idx;
      end
    end else if (cmd.update) begin
      res_qlen <= QLEN_W'(rec_new.count);
      if (is_enq && q_full) begin
        res_status <= ST_FULL;
      end else if (!is_enq && q_empty) begin
        res_status <= ST_EMPTY;
      end
    end else if (cmd.capture) begin
      res_handle <= HND_W'(store_rd);
    end
  end

  // Hold the response until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_status        <= res_status;
      rsp_handle_out    <= res_handle;
      rsp_served_output <= res_served;
      rsp_queue_length  <= res_qlen;
      rsp_total_packets <= TOT_W'(total);
    end
  end

  always_comb begin
    stat.is_qop   = is_qop;
    stat.is_clear = (op_kind == KIND_CLEAR);
    stat.is_enq   = is_enq;
    stat.is_rr    = is_rr;
    stat.bad      = bad;
    stat.rr_found = rr_found;
    stat.q_empty  = q_empty;
    stat.out_free = !rsp_valid || rsp_ready;
  end

endmodule

[hdl/virtual_output_queue_rr_top.sv]
// Top level of the per-output packet handle queues with round-robin dequeue.
// Bad index, clear, spare kind and empty round-robin requests go from decode straight to the
// response load; enqueue and empty peek/dequeue skip the handle read; others use every stage.
// Stages: decode and search, record read, update, handle read, response load.
// One request at a time: the next is accepted the cycle after the response load, which waits
// while an earlier response is held. Synchronous reset empties all queues, sets min(MAX_OUTPUTS, 32) outputs.
module virtual_output_queue_rr_top #(
  parameter int MAX_OUTPUTS  = 32,
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [voq_rr_pkg::CFG_W-1:0] cfg_wr_data,
  voq_req_if.sink                      req,
  voq_rsp_if.source                    rsp
);
  import voq_rr_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t stat;

  voq_rr_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  voq_rr_datapath #(
    .MAX_OUTPUTS  (MAX_OUTPUTS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .req_kind          (req.kind),
    .req_output_index  (req.output_index),
    .req_packet_handle (req.packet_handle),
    .rsp_ready         (rsp.ready),
    .rsp_valid         (rsp.valid),
    .rsp_status        (rsp.status),
    .rsp_handle_out    (rsp.handle_out),
    .rsp_served_output (rsp.served_output),
    .rsp_queue_length  (rsp.queue_length),
    .rsp_total_packets (rsp.total_packets),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

[hdl/voq_rr_checker.sv]
// Port checker for the output queue top level, with its bind statement.
`include "assert_macros.svh"

module voq_rr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [voq_rr_pkg::ST_W-1:0]   rsp_status,
  input logic [voq_rr_pkg::HND_W-1:0]  rsp_handle_out,
  input logic [voq_rr_pkg::IDX_W-1:0]  rsp_served_output,
  input logic [voq_rr_pkg::QLEN_W-1:0] rsp_queue_length,
  input logic [voq_rr_pkg::TOT_W-1:0]  rsp_total_packets
);
  import voq_rr_pkg::*;

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_handle_out) && $stable(rsp_served_output) && $stable(rsp_queue_length) && $stable(rsp_total_packets))
  `ASSERT_IMPL(a_no_handle_on_fail, clk, rst, rsp_valid && (rsp_status != ST_OK), rsp_handle_out == '0)
  `ASSERT_IMPL(a_bad_has_no_length, clk, rst, rsp_valid && (rsp_status == ST_BAD), rsp_queue_length == '0)
  `ASSERT_NEXT(a_one_request_at_a_time, clk, rst, req_valid && req_ready, !req_ready)

endmodule

bind virtual_output_queue_rr_top voq_rr_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_handle_out    (rsp.handle_out),
  .rsp_served_output (rsp.served_output),
  .rsp_queue_length  (rsp.queue_length),
  .rsp_total_packets (rsp.total_packets)
);
